@@ rtl/core/tld_pkg.sv @@
// Package for the traction limited drive and brake block.
// Holds field widths, register codes and the structs passed between stages.
// No dependencies.
`default_nettype none

package tld_pkg;

   localparam int TARGET_W     = 14;
   localparam int SPEED_W      = 16;
   localparam int MULT_W       = 16;
   localparam int CFG_W        = 13;
   localparam int LEVEL_W      = 4;
   localparam int CSR_INDEX_W  = 3;
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 24;
   localparam int PROD_W       = CFG_W + MULT_W;

   localparam logic [14:0]        BOOST_SAT  = 15'h7fff;
   localparam logic [LEVEL_W-1:0] FULL_BRAKE = 4'd8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LIMIT_ENABLED,
      CSR_MAX_ACCEL,
      CSR_MAX_BRAKE,
      CSR_OVERSPEED_TOL,
      CSR_DEAD_BAND,
      CSR_MIN_DUTY
   } csr_index_type;

   typedef struct packed {
      logic             limit_enabled;
      logic [CFG_W-1:0] max_accel;
      logic [CFG_W-1:0] max_brake;
      logic [CFG_W-1:0] overspeed_tolerance;
      logic [CFG_W-1:0] dead_band;
      logic [CFG_W-1:0] min_duty;
   } cfg_type;

   // handoff from the limiter to the brake/shaping stages
   typedef struct packed {
      logic                enabled;
      logic [TARGET_W-1:0] target;
      logic                brake;
      logic                full_brake;
      logic [15:0]         dividend;
      logic [16:0]         divisor;
      logic [13:0]         mag;
      logic                neg;
   } lim_item_type;

endpackage

`default_nettype wire

@@ rtl/core/tld_limit.sv @@
// Limiter stages 1-3: sign mirroring, boosted acceleration, drive limit
// and brake torque. Depends on tld_pkg.
`default_nettype none

module tld_limit #(
   parameter int FRAC_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tld_pkg::cfg_type              cfg,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire logic [tld_pkg::TARGET_W-1:0]  in_target,
   input  wire logic [tld_pkg::SPEED_W-1:0]   in_speed,
   input  wire logic [tld_pkg::MULT_W-1:0]    in_mult,
   output      logic                          out_valid,
   input  wire logic                          out_ready,
   output      tld_pkg::lim_item_type         out_item
);
   import tld_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   // stage 1
   logic                s1_en_ff, s1_en_in;
   logic [TARGET_W-1:0] s1_target_ff, s1_target_in;
   logic                s1_back_ff, s1_back_in;
   logic signed [14:0]  s1_sp_ff, s1_sp_in;
   logic [16:0]         s1_ws_ff, s1_ws_in;
   logic [PROD_W-1:0]   s1_prod_ff, s1_prod_in;
   logic signed [14:0]  sp_ext;
   logic signed [16:0]  ws_ext;

   // stage 2
   logic                s2_en_ff;
   logic [TARGET_W-1:0] s2_target_ff;
   logic                s2_back_ff;
   logic signed [14:0]  s2_sp_ff;
   logic [16:0]         s2_ws_ff;
   logic signed [17:0]  s2_err_ff, s2_err_in;
   logic [16:0]         s2_lim_hi_ff, s2_lim_hi_in;
   logic signed [17:0]  s2_lim_lo_ff, s2_lim_lo_in;
   logic                s2_ge_ff, s2_ge_in;
   logic [PROD_W-1:0]   shifted;
   logic [14:0]         boosted;

   // stage 3
   lim_item_type        s3_item_ff, s3_item_in;
   logic signed [17:0]  tol_neg, sp18, hi18, drive18, mag18, nerr;
   logic                accel;
   logic [CFG_W-1:0]    torque;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      sp_ext     = {in_target[TARGET_W-1], in_target};
      ws_ext     = {in_speed[SPEED_W-1], in_speed};
      s1_back_in = in_speed[SPEED_W-1];
      s1_sp_in   = s1_back_in ? -sp_ext : sp_ext;
      s1_ws_in   = s1_back_in ? 17'(-ws_ext) : 17'(ws_ext);
      s1_prod_in = {{MULT_W{1'b0}}, cfg.max_accel} * {{CFG_W{1'b0}}, in_mult};
      s1_en_in     = cfg.limit_enabled;
      s1_target_in = in_target;
   end

   always_comb begin
      shifted      = s1_prod_ff >> FRAC_BITS;
      boosted      = (shifted > PROD_W'(BOOST_SAT)) ? BOOST_SAT : shifted[14:0];
      s2_err_in    = $signed({{3{s1_sp_ff[14]}}, s1_sp_ff}) - $signed({1'b0, s1_ws_ff});
      s2_lim_hi_in = s1_ws_ff + {2'b0, boosted};
      s2_lim_lo_in = $signed({1'b0, s1_ws_ff}) - $signed({3'b0, boosted});
      s2_ge_in     = s1_ws_ff >= {2'b0, boosted};
   end

   always_comb begin
      tol_neg = -$signed({5'b0, cfg.overspeed_tolerance});
      accel   = s2_err_ff > tol_neg;
      sp18    = {{3{s2_sp_ff[14]}}, s2_sp_ff};
      hi18    = $signed({1'b0, s2_lim_hi_ff});
      if (accel) begin
         drive18 = (sp18 > hi18) ? hi18 : sp18;
      end else begin
         drive18 = (sp18 < s2_lim_lo_ff) ? s2_lim_lo_ff : sp18;
      end
      mag18  = drive18[17] ? -drive18 : drive18;
      nerr   = -s2_err_ff;
      torque = (nerr > $signed({5'b0, cfg.max_brake})) ? cfg.max_brake : nerr[CFG_W-1:0];

      s3_item_in.enabled    = s2_en_ff;
      s3_item_in.target     = s2_target_ff;
      s3_item_in.brake      = !accel && (!s2_sp_ff[14] || s2_ge_ff);
      s3_item_in.full_brake = {4'b0, torque} >= s2_ws_ff;
      s3_item_in.dividend   = {torque, 3'b0};
      s3_item_in.divisor    = s2_ws_ff;
      s3_item_in.mag        = mag18[13:0];
      // sign after restoring direction; zero drive counts as positive
      s3_item_in.neg        = s2_back_ff ? (!drive18[17] && drive18 != 18'sd0) : drive18[17];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         s1_en_ff     <= s1_en_in;
         s1_target_ff <= s1_target_in;
         s1_back_ff   <= s1_back_in;
         s1_sp_ff     <= s1_sp_in;
         s1_ws_ff     <= s1_ws_in;
         s1_prod_ff   <= s1_prod_in;
      end
      if (rdy2 && v1_ff) begin
         s2_en_ff     <= s1_en_ff;
         s2_target_ff <= s1_target_ff;
         s2_back_ff   <= s1_back_ff;
         s2_sp_ff     <= s1_sp_ff;
         s2_ws_ff     <= s1_ws_ff;
         s2_err_ff    <= s2_err_in;
         s2_lim_hi_ff <= s2_lim_hi_in;
         s2_lim_lo_ff <= s2_lim_lo_in;
         s2_ge_ff     <= s2_ge_in;
      end
      if (rdy3 && v2_ff) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = s3_item_ff;

endmodule

`default_nettype wire

@@ rtl/core/tld_finish.sv @@
// Stages 4-6: brake level by a three step restoring division, deadband
// removal and min-duty rescaling, final output select. Depends on tld_pkg.
`default_nettype none

module tld_finish #(
   parameter int FRAC_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tld_pkg::cfg_type              cfg,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire tld_pkg::lim_item_type         in_item,
   output      logic                          out_valid,
   input  wire logic                          out_ready,
   output      logic [tld_pkg::TARGET_W-1:0]  out_drive,
   output      logic                          out_brake,
   output      logic [tld_pkg::LEVEL_W-1:0]   out_level
);
   import tld_pkg::*;

   localparam int OW = FRAC_BITS + 1;
   localparam int CW = (OW > CFG_W) ? OW : CFG_W;
   localparam int PW = 14 + OW;
   localparam int RW = ((OW > 14) ? OW : 14) + 1;
   localparam logic [OW-1:0] ONE_Q = OW'(1) << FRAC_BITS;

   logic v4_ff, v5_ff, v6_ff;
   logic rdy4, rdy5, rdy6;

   logic [CW-1:0] min_ext, md_full;
   logic [OW-1:0] md, span;

   // stage 4
   logic                s4_en_ff, s4_brake_ff, s4_full_ff, s4_neg_ff, s4_dead_ff;
   logic [TARGET_W-1:0] s4_target_ff;
   logic                s4_q2_ff, s4_q2_in;
   logic [15:0]         s4_rem_ff, s4_rem_in;
   logic [16:0]         s4_div_ff;
   logic [PW-1:0]       s4_prod_ff, s4_prod_in;
   logic                s4_dead_in;
   logic [18:0]         d2;

   // stage 5
   logic                s5_en_ff, s5_brake_ff, s5_full_ff;
   logic [TARGET_W-1:0] s5_target_ff;
   logic                s5_q2_ff, s5_q1_ff, s5_q1_in;
   logic [15:0]         s5_rem_ff, s5_rem_in;
   logic [16:0]         s5_div_ff;
   logic [TARGET_W-1:0] s5_drive_ff, s5_drive_in;
   logic [17:0]         d1;
   logic [PW-1:0]       scaled;
   logic [RW-1:0]       r_sum, r_clamp;
   logic [13:0]         r_mag;

   // stage 6
   logic [TARGET_W-1:0] s6_drive_ff, s6_drive_in;
   logic                s6_brake_ff, s6_brake_in;
   logic [LEVEL_W-1:0]  s6_level_ff, s6_level_in;
   logic                q0;

   assign rdy6     = !v6_ff || out_ready;
   assign rdy5     = !v5_ff || rdy6;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   always_comb begin
      min_ext = CW'(cfg.min_duty);
      md_full = (min_ext > CW'(ONE_Q)) ? CW'(ONE_Q) : min_ext;
      md      = md_full[OW-1:0];
      span    = ONE_Q - md;
   end

   always_comb begin
      d2         = {in_item.divisor, 2'b0};
      s4_q2_in   = {3'b0, in_item.dividend} >= d2;
      s4_rem_in  = s4_q2_in ? 16'({3'b0, in_item.dividend} - d2) : in_item.dividend;
      s4_prod_in = PW'(in_item.mag) * PW'(span);
      s4_dead_in = {1'b0, in_item.mag} < {1'b0, cfg.dead_band};
   end

   always_comb begin
      d1        = {s4_div_ff, 1'b0};
      s5_q1_in  = {2'b0, s4_rem_ff} >= d1;
      s5_rem_in = s5_q1_in ? 16'({2'b0, s4_rem_ff} - d1) : s4_rem_ff;
      scaled    = s4_prod_ff >> FRAC_BITS;
      r_sum     = RW'(md) + RW'(scaled);
      r_clamp   = (r_sum > RW'(ONE_Q)) ? RW'(ONE_Q) : r_sum;
      r_mag     = r_clamp[13:0];
      if (s4_dead_ff) begin
         s5_drive_in = '0;
      end else if (s4_neg_ff) begin
         s5_drive_in = -r_mag;
      end else begin
         s5_drive_in = r_mag;
      end
   end

   always_comb begin
      q0 = {1'b0, s5_rem_ff} >= s5_div_ff;
      if (!s5_en_ff) begin
         s6_drive_in = s5_target_ff;
         s6_brake_in = 1'b0;
         s6_level_in = '0;
      end else if (s5_brake_ff) begin
         s6_drive_in = '0;
         s6_brake_in = 1'b1;
         s6_level_in = s5_full_ff ? FULL_BRAKE : {1'b0, s5_q2_ff, s5_q1_ff, q0};
      end else begin
         s6_drive_in = s5_drive_ff;
         s6_brake_in = 1'b0;
         s6_level_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy4) v4_ff <= in_valid;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && in_valid) begin
         s4_en_ff     <= in_item.enabled;
         s4_target_ff <= in_item.target;
         s4_brake_ff  <= in_item.brake;
         s4_full_ff   <= in_item.full_brake;
         s4_neg_ff    <= in_item.neg;
         s4_dead_ff   <= s4_dead_in;
         s4_q2_ff     <= s4_q2_in;
         s4_rem_ff    <= s4_rem_in;
         s4_div_ff    <= in_item.divisor;
         s4_prod_ff   <= s4_prod_in;
      end
      if (rdy5 && v4_ff) begin
         s5_en_ff     <= s4_en_ff;
         s5_target_ff <= s4_target_ff;
         s5_brake_ff  <= s4_brake_ff;
         s5_full_ff   <= s4_full_ff;
         s5_q2_ff     <= s4_q2_ff;
         s5_q1_ff     <= s5_q1_in;
         s5_rem_ff    <= s5_rem_in;
         s5_div_ff    <= s4_div_ff;
         s5_drive_ff  <= s5_drive_in;
      end
      if (rdy6 && v5_ff) begin
         s6_drive_ff <= s6_drive_in;
         s6_brake_ff <= s6_brake_in;
         s6_level_ff <= s6_level_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_drive = s6_drive_ff;
   assign out_brake = s6_brake_ff;
   assign out_level = s6_level_ff;

endmodule

`default_nettype wire

@@ rtl/core/traction_limited_drive_brake.sv @@
// Top level of the traction limited drive and brake block: register file,
// limiter pipeline and brake/shaping pipeline. Depends on tld_pkg,
// tld_limit and tld_finish.
`default_nettype none

// Takes one request per cycle while the response side is not stalled and
// returns one response per request, in order: three register stages
// mirror the signs and limit the drive, three more run the brake level
// division one quotient bit per stage alongside the deadband rescale.
// Each stage holds its item while the stage after it is full and stalled,
// so empty stages keep taking requests. Registers are written through the
// csr channel, which is always ready; write them only while the pipeline is
// empty. Indexes above the last register are ignored.
module traction_limited_drive_brake #(
   parameter int FRAC_BITS = 12
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // csr
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [tld_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tld_pkg::CFG_W-1:0]        csr_data,
   // request: target_drive[13:0], measured_speed[29:14], accel_multiplier[45:30]
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [tld_pkg::REQ_DATA_W-1:0]   req_tdata,
   // response: motor_drive[13:0], brake_engaged[14], brake_level[18:15]
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [tld_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import tld_pkg::*;

   cfg_type             cfg_ff, cfg_in;
   lim_item_type        lim_item;
   logic                lim_valid, lim_ready;
   logic [TARGET_W-1:0] motor_drive;
   logic                brake_engaged;
   logic [LEVEL_W-1:0]  brake_level;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LIMIT_ENABLED: cfg_in.limit_enabled       = csr_data[0];
            CSR_MAX_ACCEL:     cfg_in.max_accel           = csr_data;
            CSR_MAX_BRAKE:     cfg_in.max_brake           = csr_data;
            CSR_OVERSPEED_TOL: cfg_in.overspeed_tolerance = csr_data;
            CSR_DEAD_BAND:     cfg_in.dead_band           = csr_data;
            CSR_MIN_DUTY:      cfg_in.min_duty            = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit_enabled       <= 1'b1;
         cfg_ff.max_accel           <= 13'd410;
         cfg_ff.max_brake           <= 13'd410;
         cfg_ff.overspeed_tolerance <= 13'd0;
         cfg_ff.dead_band           <= 13'd128;
         cfg_ff.min_duty            <= 13'd576;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tld_limit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_limit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_target (req_tdata[13:0]),
      .in_speed  (req_tdata[29:14]),
      .in_mult   (req_tdata[45:30]),
      .out_valid (lim_valid),
      .out_ready (lim_ready),
      .out_item  (lim_item)
   );

   tld_finish #(
      .FRAC_BITS (FRAC_BITS)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (lim_valid),
      .in_ready  (lim_ready),
      .in_item   (lim_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_drive (motor_drive),
      .out_brake (brake_engaged),
      .out_level (brake_level)
   );

   assign rsp_tdata = {5'b0, brake_level, brake_engaged, motor_drive};

`ifndef NO_ASSERTIONS
   a_brake_zero_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && brake_engaged |-> motor_drive == '0)
      else $error("brake engaged with nonzero drive");

   a_coast_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !brake_engaged |-> brake_level == '0)
      else $error("brake level set while coasting");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && brake_engaged |-> brake_level <= FULL_BRAKE)
      else $error("brake level above full brake");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
`endif

endmodule

`default_nettype wire
